>>> rtl/core/bcas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcas_pkg: shared types and constants
// Payload structs, register indexes and limits for the bounded confidence step.
// ----------------------------------------------------------------------------
package bcas_pkg;

    localparam int NumAgents = 16;
    localparam int IdxW = 4;

    localparam logic [1:0] REG_POPULATION = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_PULL = 2'd2;

    localparam logic ACT_INTERACT = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [3:0]  first_index;
        logic [3:0]  second_index;
        logic [15:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] first_value;
        logic [15:0] second_value;
        logic        interacted;
        logic [15:0] mean_value;
        logic [14:0] spread_variance;
        logic [4:0]  cluster_count;
    } out_item_t;

    typedef struct packed {
        logic [15:0] v_first;
        logic [15:0] v_second;
    } pair_t;

endpackage

>>> rtl/core/bounded_confidence_agent_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_confidence_agent_step: bounded confidence opinion agent block
// Keeps 16 agent values, applies a write or a pair interaction per item and
// reports mean, variance and cluster count over the active agents.
// ----------------------------------------------------------------------------
// sequence from input transfer to result valid: update, sum over n agents, mean divide,
// squares over n agents, variance divide, copy, insertion sort and gap scan; 16 agents
// throughput: one item at a time, in not ready until the result is taken
// the sums share one accumulator, mean and variance share one serial divider
// reset: agents cleared to zero, registers at their reset values
module bounded_confidence_agent_step
    import bcas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_MOVE   = 10'b0000000010,
        S_SUM    = 10'b0000000100,
        S_MDIV   = 10'b0000001000,
        S_SQ     = 10'b0000010000,
        S_VDIV   = 10'b0000100000,
        S_SORT   = 10'b0001000000,
        S_GAP    = 10'b0010000000,
        S_OUT    = 10'b0100000000,
        S_COPY   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [15:0] agent_reg [NumAgents];
    logic [15:0] srt_reg [NumAgents];
    logic [4:0]  pop_reg;
    logic [16:0] thr_reg;
    logic [15:0] pull_reg;
    in_item_t    item_reg;
    out_item_t   res_reg;
    logic [4:0]  i_reg, j_reg;
    logic [39:0] acc_reg;
    logic [15:0] mean_reg;
    logic [15:0] key_reg;
    logic        div_start;
    logic        div_go_reg, div_go_next;
    logic        div_done;
    logic [39:0] div_q;
    logic [4:0]  n_eff;
    logic [16:0] t_eff;
    logic [15:0] mu_eff;
    pair_t       pr;
    logic signed [16:0] d;
    logic [16:0] ad;
    logic signed [33:0] prod;
    logic signed [17:0] mv;
    logic signed [18:0] ni, nj;
    logic        valid_pair;
    logic signed [16:0] dv;
    logic signed [33:0] dsq;
    logic [15:0] upper, lower;

    assign n_eff = (pop_reg < 5'd2) ? 5'd2 : ((pop_reg > 5'd16) ? 5'd16 : pop_reg);
    assign t_eff = (thr_reg < 17'd66) ? 17'd66 :
                   ((thr_reg > 17'd65536) ? 17'd65536 : thr_reg);
    assign mu_eff = (pull_reg > 16'd32768) ? 16'd32768 : pull_reg;

    assign div_start = div_go_reg;

    bcas_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(acc_reg), .divisor(n_eff), .done(div_done), .quotient(div_q)
    );

    assign pr.v_first = agent_reg[item_reg.first_index];
    assign pr.v_second = agent_reg[item_reg.second_index];
    assign d = $signed({1'b0, pr.v_second}) - $signed({1'b0, pr.v_first});
    assign ad = d[16] ? 17'(-d) : 17'(d);
    assign prod = d * $signed({1'b0, mu_eff});
    assign mv = 18'(prod >>> 16);
    assign ni = 19'(pr.v_first) + 19'(mv);
    assign nj = 19'(pr.v_second) - 19'(mv);
    assign valid_pair = ({1'b0, item_reg.first_index} < n_eff) &&
                        ({1'b0, item_reg.second_index} < n_eff) &&
                        (item_reg.first_index != item_reg.second_index);
    assign dv = $signed({1'b0, agent_reg[i_reg[3:0]]}) - $signed({1'b0, mean_reg});
    assign dsq = dv * dv;
    assign upper = srt_reg[j_reg[3:0] - 4'd1];
    assign lower = srt_reg[i_reg[3:0] - 4'd1];

    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data = res_reg;

    always_comb
    begin
        state_next = state_reg;
        div_go_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_MOVE;
            end
            S_MOVE:  state_next = S_SUM;
            S_SUM:
            begin
                if (i_reg == n_eff - 5'd1)
                begin
                    state_next = S_MDIV;
                    div_go_next = 1'b1;
                end
            end
            S_MDIV:
            begin
                if (div_done)
                    state_next = S_SQ;
            end
            S_SQ:
            begin
                if (i_reg == n_eff - 5'd1)
                begin
                    state_next = S_VDIV;
                    div_go_next = 1'b1;
                end
            end
            S_VDIV:
            begin
                if (div_done)
                    state_next = S_COPY;
            end
            S_COPY:  state_next = S_SORT;
            S_SORT:
            begin
                if (i_reg == n_eff)
                    state_next = S_GAP;
            end
            S_GAP:
            begin
                if (i_reg == n_eff)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            div_go_reg <= 1'b0;
            pop_reg <= 5'd16;
            thr_reg <= 17'd14418;
            pull_reg <= 16'd19661;
            for (int k = 0; k < NumAgents; k++)
                agent_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            div_go_reg <= div_go_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POPULATION: pop_reg <= cfg_data[4:0];
                    REG_THRESHOLD:  thr_reg <= cfg_data;
                    REG_PULL:       pull_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (state_reg == S_MOVE)
            begin
                if (item_reg.action == ACT_WRITE)
                    agent_reg[item_reg.first_index] <= item_reg.write_value;
                else if (valid_pair && (ad < t_eff))
                begin
                    agent_reg[item_reg.first_index] <=
                        ni[18] ? 16'd0 : (ni > 19'sd65535 ? 16'hffff : ni[15:0]);
                    agent_reg[item_reg.second_index] <=
                        nj[18] ? 16'd0 : (nj > 19'sd65535 ? 16'hffff : nj[15:0]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                item_reg <= in_data;
                i_reg <= '0;
                acc_reg <= '0;
            end
            S_MOVE:
            begin
                res_reg.interacted <= (item_reg.action == ACT_INTERACT) &&
                                      valid_pair && (ad < t_eff);
            end
            S_SUM:
            begin
                acc_reg <= acc_reg + 40'(agent_reg[i_reg[3:0]]);
                i_reg <= i_reg + 5'd1;
            end
            S_MDIV:
            begin
                i_reg <= '0;
                if (div_done)
                begin
                    mean_reg <= div_q[15:0];
                    res_reg.mean_value <= div_q[15:0];
                    acc_reg <= '0;
                end
            end
            S_SQ:
            begin
                acc_reg <= acc_reg + 40'($unsigned(dsq));
                i_reg <= i_reg + 5'd1;
            end
            S_VDIV:
            begin
                if (div_done)
                    res_reg.spread_variance <= (div_q[39:16] > 24'd16384) ?
                        15'd16384 : div_q[30:16];
            end
            S_COPY:
            begin
                i_reg <= '0;
                j_reg <= '0;
                key_reg <= agent_reg[0];
                res_reg.first_value <= agent_reg[item_reg.first_index];
                res_reg.second_value <= agent_reg[item_reg.second_index];
            end
            S_SORT:
            begin
                if (i_reg != n_eff)
                begin
                    if (j_reg != 5'd0 && upper > key_reg)
                    begin
                        srt_reg[j_reg[3:0]] <= upper;
                        j_reg <= j_reg - 5'd1;
                    end
                    else
                    begin
                        srt_reg[j_reg[3:0]] <= key_reg;
                        i_reg <= i_reg + 5'd1;
                        j_reg <= i_reg + 5'd1;
                        key_reg <= agent_reg[4'(i_reg + 5'd1)];
                    end
                end
                else
                begin
                    i_reg <= 5'd1;
                    res_reg.cluster_count <= 5'd1;
                end
            end
            S_GAP:
            begin
                if (i_reg != n_eff)
                begin
                    if ({1'b0, srt_reg[i_reg[3:0]] - lower} > t_eff)
                        res_reg.cluster_count <= res_reg.cluster_count + 5'd1;
                    i_reg <= i_reg + 5'd1;
                end
            end
            default: ;
        endcase
    end

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed while waiting");

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("input taken while busy");

    property p_clusters;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.cluster_count != 5'd0 && out_data.cluster_count <= n_eff);
    endproperty
    a_clusters: assert property (p_clusters) else $error("cluster count out of range");

endmodule

>>> rtl/core/bcas_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcas_div: restoring divider
// Divides a 40-bit dividend by a 5-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcas_div
    import bcas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [4:0]  divisor,
    output logic        done,
    output logic [39:0] quotient
);

    logic [39:0] q_reg, q_next;
    logic [5:0]  r_reg, r_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [5:0]  trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg[4:0], q_reg[39]};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            cnt_next = 6'd40;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                r_next = trial - {1'b0, divisor};
                q_next = {q_reg[38:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[38:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done = busy_reg && (cnt_reg == 6'd1);
    assign quotient = {q_reg[38:0], (trial >= {1'b0, divisor})};

endmodule

>>> tb/bounded_confidence_agent_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_confidence_agent_step_tb: self-checking bench for the agent block
// Drives write and interact items with random gaps, predicts each result from
// an internal copy of the agent values and registers, and compares per field.
// ----------------------------------------------------------------------------
module bounded_confidence_agent_step_tb;
    import bcas_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    bounded_confidence_agent_step dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    in_item_t  pending_items[$];
    out_item_t expected_stats[$];
    logic [15:0] agents_model[NumAgents];
    logic [4:0]  population_reg;
    logic [16:0] threshold_reg;
    logic [15:0] pull_reg;
    int errors;
    int send_wait;
    int recv_wait;
    bit sender_hold;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic out_item_t predict_step(in_item_t it);
        out_item_t r;
        int n;
        int thr;
        int mu;
        longint d;
        longint p;
        longint m;
        longint ni;
        longint nj;
        longint sum;
        longint mean;
        longint sq;
        longint var_q;
        int srt[NumAgents];
        int t;
        int k;
        int clusters;
        n = int'(population_reg);
        n = n < 2 ? 2 : (n > NumAgents ? NumAgents : n);
        thr = int'(threshold_reg);
        thr = thr < 66 ? 66 : (thr > 65536 ? 65536 : thr);
        mu = int'(pull_reg);
        mu = mu > 32768 ? 32768 : mu;
        r = '0;
        if (it.action == ACT_WRITE) begin
            agents_model[it.first_index] = it.write_value;
        end else if (it.first_index < n && it.second_index < n
                     && it.first_index != it.second_index) begin
            d = longint'(agents_model[it.second_index]) - longint'(agents_model[it.first_index]);
            if ((d < 0 ? -d : d) < thr) begin
                p = d * mu;
                m = p >>> 16;
                ni = longint'(agents_model[it.first_index]) + m;
                nj = longint'(agents_model[it.second_index]) - m;
                ni = ni < 0 ? 0 : (ni > 65535 ? 65535 : ni);
                nj = nj < 0 ? 0 : (nj > 65535 ? 65535 : nj);
                agents_model[it.first_index] = ni[15:0];
                agents_model[it.second_index] = nj[15:0];
                r.interacted = 1'b1;
            end
        end
        sum = 0;
        for (int i = 0; i < n; i++) sum += longint'(agents_model[i]);
        mean = sum / n;
        sq = 0;
        for (int i = 0; i < n; i++)
            sq += (longint'(agents_model[i]) - mean) * (longint'(agents_model[i]) - mean);
        var_q = (sq / n) >> 16;
        if (var_q > 16384) var_q = 16384;
        for (int i = 0; i < n; i++) begin
            t = int'(agents_model[i]);
            k = i;
            while (k > 0 && srt[k-1] > t) begin
                srt[k] = srt[k-1];
                k--;
            end
            srt[k] = t;
        end
        clusters = 1;
        for (int i = 1; i < n; i++) if (srt[i] - srt[i-1] > thr) clusters++;
        r.first_value = agents_model[it.first_index];
        r.second_value = agents_model[it.second_index];
        r.mean_value = mean[15:0];
        r.spread_variance = var_q[14:0];
        r.cluster_count = clusters[4:0];
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_wait <= 0;
        end else if (in_valid && !in_ready) begin
        end else if (send_wait > 0) begin
            in_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end else if (pending_items.size() > 0 && !sender_hold) begin
            in_valid <= 1'b1;
            in_data <= pending_items[0];
            expected_stats.push_back(predict_step(pending_items.pop_front()));
            send_wait <= int'($urandom_range(0, 3));
        end else begin
            in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_stats.size() == 0) begin
                    $error("unexpected transfer %h", out_data);
                    errors++;
                end else begin
                    out_item_t e;
                    e = expected_stats.pop_front();
                    if (out_data.first_value !== e.first_value) begin
                        $error("first_value exp %0d got %0d", e.first_value, out_data.first_value);
                        errors++;
                    end
                    if (out_data.second_value !== e.second_value) begin
                        $error("second_value exp %0d got %0d", e.second_value,
                               out_data.second_value);
                        errors++;
                    end
                    if (out_data.interacted !== e.interacted) begin
                        $error("interacted exp %0d got %0d", e.interacted, out_data.interacted);
                        errors++;
                    end
                    if (out_data.mean_value !== e.mean_value) begin
                        $error("mean_value exp %0d got %0d", e.mean_value, out_data.mean_value);
                        errors++;
                    end
                    if (out_data.spread_variance !== e.spread_variance) begin
                        $error("spread_variance exp %0d got %0d", e.spread_variance,
                               out_data.spread_variance);
                        errors++;
                    end
                    if (out_data.cluster_count !== e.cluster_count) begin
                        $error("cluster_count exp %0d got %0d", e.cluster_count,
                               out_data.cluster_count);
                        errors++;
                    end
                end
                recv_wait <= int'($urandom_range(0, 3));
                out_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_stats.size() > 0 || in_valid)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_POPULATION: population_reg = val[4:0];
            REG_THRESHOLD: threshold_reg = val;
            REG_PULL: pull_reg = val[15:0];
            default: ;
        endcase
    endtask

    function automatic in_item_t make_item(logic act, logic [3:0] a, logic [3:0] b,
                                           logic [15:0] v);
        in_item_t it;
        it.action = act;
        it.first_index = a;
        it.second_index = b;
        it.write_value = v;
        return it;
    endfunction

    task automatic random_phase(int count, int pop_hint);
        in_item_t it;
        int base;
        base = int'($urandom);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 3) begin
                // writes mostly cluster near a random base so that many pairs fall inside the threshold
                it = make_item(ACT_WRITE, 4'($urandom_range(0, 15)), 4'($urandom),
                               $urandom_range(0, 3) == 0 ? 16'($urandom) :
                               16'(base + int'($urandom_range(0, 9000))));
            end else if ($urandom_range(0, 9) < 8) begin
                it = make_item(ACT_INTERACT, 4'($urandom_range(0, pop_hint - 1)),
                               4'($urandom_range(0, pop_hint - 1)), 16'($urandom));
            end else begin
                it = make_item(ACT_INTERACT, 4'($urandom), 4'($urandom), 16'($urandom));
            end
            pending_items.push_back(it);
        end
    endtask

    initial begin
        errors = 0;
        sender_hold = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_POPULATION;
        cfg_data = '0;
        population_reg = 5'd16;
        threshold_reg = 17'd14418;
        pull_reg = 16'd19661;
        for (int i = 0; i < NumAgents; i++) agents_model[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        pending_items.push_back(make_item(ACT_INTERACT, 4'd0, 4'd1, 16'hFFFF));
        pending_items.push_back(make_item(ACT_WRITE, 4'd0, 4'd15, 16'hFFFF));
        pending_items.push_back(make_item(ACT_WRITE, 4'd15, 4'd0, 16'h0000));
        pending_items.push_back(make_item(ACT_WRITE, 4'd1, 4'd0, 16'hF000));
        pending_items.push_back(make_item(ACT_INTERACT, 4'd0, 4'd1, 16'h0));
        pending_items.push_back(make_item(ACT_INTERACT, 4'd1, 4'd0, 16'h0));
        pending_items.push_back(make_item(ACT_INTERACT, 4'd3, 4'd3, 16'h0));
        pending_items.push_back(make_item(ACT_WRITE, 4'd2, 4'd3, 16'h8000));
        pending_items.push_back(make_item(ACT_INTERACT, 4'd2, 4'd0, 16'h0));
        pending_items.push_back(make_item(ACT_INTERACT, 4'd15, 4'd14, 16'h0));
        pending_items.push_back(make_item(ACT_WRITE, 4'd7, 4'd7, 16'h5555));
        pending_items.push_back(make_item(ACT_WRITE, 4'd8, 4'd7, 16'hAAAA));
        wait_drained();

        write_reg(REG_POPULATION, 17'd2);
        write_reg(REG_THRESHOLD, 17'd65536);
        write_reg(REG_PULL, 17'd32768);
        pending_items.push_back(make_item(ACT_WRITE, 4'd1, 4'd0, 16'h0001));
        pending_items.push_back(make_item(ACT_INTERACT, 4'd0, 4'd1, 16'h0));
        pending_items.push_back(make_item(ACT_INTERACT, 4'd0, 4'd2, 16'h0));
        pending_items.push_back(make_item(ACT_WRITE, 4'd5, 4'd1, 16'h1234));
        random_phase(200, 2);
        wait_drained();

        write_reg(REG_POPULATION, 17'd0);
        write_reg(REG_THRESHOLD, 17'd1);
        write_reg(REG_PULL, 17'hFFFF);
        write_reg(2'd3, 17'h1FFFF);
        random_phase(200, 2);
        wait_drained();

        write_reg(REG_POPULATION, 17'd31);
        write_reg(REG_THRESHOLD, 17'h1FFFF);
        write_reg(REG_PULL, 17'd0);
        random_phase(250, 16);
        wait_drained();

        write_reg(REG_POPULATION, 17'd7);
        write_reg(REG_THRESHOLD, 17'd66);
        write_reg(REG_PULL, 17'd1);
        random_phase(250, 7);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_POPULATION, 17'($urandom_range(2, 16)));
            write_reg(REG_THRESHOLD, 17'($urandom_range(66, 65536)));
            write_reg(REG_PULL, 17'($urandom_range(0, 32768)));
            random_phase(120, int'(population_reg));
            sender_hold = 1'b1;
            while (expected_stats.size() > 0 || in_valid) @(posedge clk);
            sender_hold = 1'b0;
            random_phase(120, int'(population_reg));
            wait_drained();
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
